// ===== hdl/variable_record_stack_assert.svh =====
// Assertion macros shared by the record stack modules.
`ifndef VARIABLE_RECORD_STACK_ASSERT_SVH
`define VARIABLE_RECORD_STACK_ASSERT_SVH

`ifndef SYNTHESIS
// Checked property, disabled while reset is asserted.
`define VRS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("variable_record_stack: assertion failed");
// Checked property that also holds during reset.
`define VRS_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("variable_record_stack: assertion failed");
`else
`define VRS_ASSERT(name, clk, rst_n, prop)
`define VRS_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// ===== hdl/vrs_pkg.sv =====
// Package: types, codes and default sizes of the record stack.
package vrs_pkg;

  // Fixed field widths
  localparam int OP_W   = 2;
  localparam int LEN_W  = 7;
  localparam int BYTE_W = 8;
  localparam int FREE_W = 13;

  // Default sizes
  localparam int DEF_STACK_BYTES = 4096;
  localparam int DEF_LEN_BYTES   = 8;
  localparam int DEF_MAX_RECORD  = 64;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;    // latch the input word
    logic push_step;  // one push byte
    logic drop_push;  // abandon a push in progress
    logic clear_top;  // empty the stack
    logic rd_trail;   // read the top record's length byte
    logic setup;      // size the record, read its first byte
    logic rd_next;    // read the following record byte
    logic trail_wr;   // write the length byte of a finished push
    logic emit;       // load the output register
    logic emit_ok;
    logic emit_data;
    logic emit_last;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    op_e  op;
    logic top_zero;
    logic push_done;
    logic n_zero;
    logic cnt_one;
    logic slot_free;
  } sts_t;

endpackage

// ===== hdl/variable_record_stack.sv =====
// Top level of the variable-length record stack.
//
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_stall_o   opcode_i, length_i, in_byte_i
//  out      output     out_valid_o / out_stall_i ok_o, out_byte_o, last_o,
//                                                empty_res_o, fits_o, free_bytes_o
//
// The last byte of a pushed record is followed by a write of its length byte.
// Pop and peek read the length byte and size the record, then return its bytes one
// per cycle while the output is not stalled, from the single read port of the byte store.
// Reset clears the top pointer and push state; the byte store is not cleared.
// A stalled output word holds; one item may be accepted while it waits.
module variable_record_stack #(
  parameter int STACK_BYTES = vrs_pkg::DEF_STACK_BYTES,
  parameter int LEN_BYTES   = vrs_pkg::DEF_LEN_BYTES,
  parameter int MAX_RECORD  = vrs_pkg::DEF_MAX_RECORD
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [vrs_pkg::OP_W-1:0]    opcode_i,
  input  logic [vrs_pkg::LEN_W-1:0]   length_i,
  input  logic [vrs_pkg::BYTE_W-1:0]  in_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        ok_o,
  output logic [vrs_pkg::BYTE_W-1:0]  out_byte_o,
  output logic                        last_o,
  output logic                        empty_res_o,
  output logic                        fits_o,
  output logic [vrs_pkg::FREE_W-1:0]  free_bytes_o
);
  import vrs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  vrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vrs_dpath #(
    .STACK_BYTES (STACK_BYTES),
    .LEN_BYTES   (LEN_BYTES),
    .MAX_RECORD  (MAX_RECORD)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .opcode_i     (opcode_i),
    .length_i     (length_i),
    .in_byte_i    (in_byte_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .ok_o         (ok_o),
    .out_byte_o   (out_byte_o),
    .last_o       (last_o),
    .empty_res_o  (empty_res_o),
    .fits_o       (fits_o),
    .free_bytes_o (free_bytes_o)
  );

endmodule

// ===== hdl/vrs_ctrl.sv =====
// Controller state machine of the record stack.
`include "variable_record_stack_assert.svh"

module vrs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  vrs_pkg::sts_t sts_i,
  output vrs_pkg::cmd_t cmd_o
);
  import vrs_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXEC  = 7'b0000010,
    S_TRAIL = 7'b0000100,
    S_SETUP = 7'b0001000,
    S_ZERO  = 7'b0010000,
    S_BYTE  = 7'b0100000,
    S_SPARE = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts_i.op)
          OP_PUSH: begin
            if (sts_i.slot_free) begin
              cmd_o.push_step = 1'b1;
              cmd_o.emit      = 1'b1;
              cmd_o.emit_last = 1'b1;
              state_d         = sts_i.push_done ? S_TRAIL : S_IDLE;
            end
          end
          OP_CLEAR: begin
            cmd_o.drop_push = 1'b1;
            if (sts_i.slot_free) begin
              cmd_o.clear_top = 1'b1;
              cmd_o.emit      = 1'b1;
              cmd_o.emit_ok   = 1'b1;
              cmd_o.emit_last = 1'b1;
              state_d         = S_IDLE;
            end
          end
          OP_POP, OP_PEEK: begin
            cmd_o.drop_push = 1'b1;
            if (sts_i.top_zero) begin
              if (sts_i.slot_free) begin
                cmd_o.emit      = 1'b1;
                cmd_o.emit_last = 1'b1;
                state_d         = S_IDLE;
              end
            end else begin
              cmd_o.rd_trail = 1'b1;
              state_d        = S_SETUP;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_TRAIL: begin
        cmd_o.trail_wr = 1'b1;
        state_d        = S_IDLE;
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = sts_i.n_zero ? S_ZERO : S_BYTE;
      end
      S_ZERO: begin
        if (sts_i.slot_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_ok   = 1'b1;
          cmd_o.emit_last = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_BYTE: begin
        if (sts_i.slot_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_ok   = 1'b1;
          cmd_o.emit_data = 1'b1;
          cmd_o.emit_last = sts_i.cnt_one;
          if (sts_i.cnt_one) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.rd_next = 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `VRS_ASSERT(a_accept_to_exec, clk_i, rst_ni, in_valid_i && !in_stall_o |=> state_q == S_EXEC)
  `VRS_ASSERT(a_trail_after_push, clk_i, rst_ni, state_q == S_TRAIL |-> $past(cmd_o.push_step))
  `VRS_ASSERT(a_byte_after_setup, clk_i, rst_ni, $rose(state_q == S_BYTE) |-> $past(cmd_o.setup))

endmodule

// ===== hdl/vrs_dpath.sv =====
// Datapath of the record stack: byte store, top pointer, push state, output register.
`include "variable_record_stack_assert.svh"

module vrs_dpath #(
  parameter int STACK_BYTES = vrs_pkg::DEF_STACK_BYTES,
  parameter int LEN_BYTES   = vrs_pkg::DEF_LEN_BYTES,
  parameter int MAX_RECORD  = vrs_pkg::DEF_MAX_RECORD
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [vrs_pkg::OP_W-1:0]    opcode_i,
  input  logic [vrs_pkg::LEN_W-1:0]   length_i,
  input  logic [vrs_pkg::BYTE_W-1:0]  in_byte_i,
  input  vrs_pkg::cmd_t               cmd_i,
  output vrs_pkg::sts_t               sts_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        ok_o,
  output logic [vrs_pkg::BYTE_W-1:0]  out_byte_o,
  output logic                        last_o,
  output logic                        empty_res_o,
  output logic                        fits_o,
  output logic [vrs_pkg::FREE_W-1:0]  free_bytes_o
);
  import vrs_pkg::*;

  localparam int ADDR_W = $clog2(STACK_BYTES);
  localparam int TOP_W  = $clog2(STACK_BYTES + 1);
  localparam int CMP_W  = (TOP_W > FREE_W ? TOP_W : FREE_W) + 1;
  localparam logic [TOP_W-1:0] TOP_LEN = TOP_W'(LEN_BYTES);
  localparam logic [CMP_W-1:0] CMP_LEN = CMP_W'(LEN_BYTES);
  localparam logic [CMP_W-1:0] CMP_STK = CMP_W'(STACK_BYTES);
  localparam logic [LEN_W-1:0] MAX_L   = LEN_W'(MAX_RECORD);

  // Captured input word
  op_e               op_q;
  logic [LEN_W-1:0]  len_q;
  logic [BYTE_W-1:0] byte_q;

  // Stack and push state
  logic [TOP_W-1:0]  top_q, top_d;
  logic [LEN_W-1:0]  left_q, rec_q;
  logic              rej_q;

  // Read walk
  logic [ADDR_W-1:0] ptr_q;
  logic [LEN_W-1:0]  cnt_q;

  // Byte store
  logic [BYTE_W-1:0] mem [STACK_BYTES];
  logic [BYTE_W-1:0] rd_data_q;
  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [BYTE_W-1:0] wr_data;

  // Output register
  logic              out_valid_q;
  logic              ok_q, last_q, empty_q, fits_q;
  logic [BYTE_W-1:0] obyte_q;
  logic [FREE_W-1:0] free_q;
  logic              slot_free;

  // Push decode
  logic              first, zero_len, over, eff_rej, push_ok, push_done;
  logic [LEN_W-1:0]  eff_len, eff_left, left_nx;
  logic [CMP_W-1:0]  len_ext, free_now, free_nx;
  logic [ADDR_W-1:0] push_addr;

  // Record sizing
  logic [TOP_W-1:0]  t_top, base;
  logic [LEN_W-1:0]  cap1, stored, n_val;
  logic              fits_nx;

  // Input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_e'(opcode_i);
      len_q  <= length_i;
      byte_q <= in_byte_i;
    end
  end

  // Push step decode
  always_comb begin
    len_ext   = CMP_W'(len_q);
    free_now  = CMP_STK - CMP_W'(top_q);
    first     = (left_q == '0);
    zero_len  = first && (len_q == '0);
    eff_len   = first ? len_q : rec_q;
    eff_left  = first ? len_q : left_q;
    over      = (len_q > MAX_L) || (len_ext + CMP_LEN > free_now);
    eff_rej   = first ? over : rej_q;
    left_nx   = eff_left - LEN_W'(1);
    push_ok   = !zero_len && !eff_rej;
    push_done = push_ok && (left_nx == '0);
    push_addr = ADDR_W'(CMP_W'(top_q) + CMP_W'(eff_len - eff_left));
  end

  // Top record sizing from its length byte
  always_comb begin
    t_top  = top_q - TOP_LEN;
    cap1   = (rd_data_q[LEN_W-1:0] > MAX_L) ? MAX_L : rd_data_q[LEN_W-1:0];
    stored = (CMP_W'(cap1) > CMP_W'(t_top)) ? LEN_W'(t_top) : cap1;
    base   = t_top - TOP_W'(stored);
    n_val  = (len_q < stored) ? len_q : stored;
  end

  // Next top pointer
  always_comb begin
    priority if (cmd_i.clear_top) begin
      top_d = '0;
    end else if (cmd_i.push_step && push_done) begin
      top_d = TOP_W'(CMP_W'(top_q) + CMP_W'(eff_len) + CMP_LEN);
    end else if (cmd_i.setup && op_q == OP_POP) begin
      top_d = base;
    end else begin
      top_d = top_q;
    end
  end

  // Status fields after this step
  always_comb begin
    free_nx = CMP_STK - CMP_W'(top_d);
    fits_nx = (len_q != '0) && (len_q <= MAX_L) && (len_ext + CMP_LEN <= free_nx);
  end

  // Store ports
  always_comb begin
    wr_en   = (cmd_i.push_step && push_ok) || cmd_i.trail_wr;
    wr_addr = cmd_i.trail_wr ? ADDR_W'(top_q - TOP_LEN) : push_addr;
    wr_data = cmd_i.trail_wr ? BYTE_W'(rec_q) : byte_q;
    rd_en   = cmd_i.rd_trail || cmd_i.setup || cmd_i.rd_next;
    priority if (cmd_i.rd_trail) begin
      rd_addr = ADDR_W'(t_top);
    end else if (cmd_i.setup) begin
      rd_addr = ADDR_W'(base);
    end else begin
      rd_addr = ptr_q + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Stack, push and walk registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q  <= '0;
      left_q <= '0;
      rec_q  <= '0;
      rej_q  <= 1'b0;
      ptr_q  <= '0;
      cnt_q  <= '0;
    end else begin
      top_q <= top_d;
      if (cmd_i.drop_push) begin
        left_q <= '0;
        rec_q  <= '0;
        rej_q  <= 1'b0;
      end else if (cmd_i.push_step && !zero_len) begin
        left_q <= left_nx;
        rec_q  <= eff_len;
        rej_q  <= eff_rej && (left_nx != '0);
      end
      if (cmd_i.setup) begin
        ptr_q <= ADDR_W'(base);
        cnt_q <= n_val;
      end else if (cmd_i.rd_next) begin
        ptr_q <= ptr_q + ADDR_W'(1);
        cnt_q <= cnt_q - LEN_W'(1);
      end
    end
  end

  // Output word register
  assign slot_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.emit || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      ok_q    <= cmd_i.push_step ? push_ok : cmd_i.emit_ok;
      obyte_q <= cmd_i.emit_data ? rd_data_q : '0;
      last_q  <= cmd_i.emit_last;
      empty_q <= (top_d == '0);
      fits_q  <= fits_nx;
      free_q  <= free_nx[FREE_W-1:0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ok_o         = ok_q;
  assign out_byte_o   = obyte_q;
  assign last_o       = last_q;
  assign empty_res_o  = empty_q;
  assign fits_o       = fits_q;
  assign free_bytes_o = free_q;

  // Status to the controller
  always_comb begin
    sts_o.op        = op_q;
    sts_o.top_zero  = (top_q == '0);
    sts_o.push_done = push_done;
    sts_o.n_zero    = (n_val == '0);
    sts_o.cnt_one   = (cnt_q == LEN_W'(1));
    sts_o.slot_free = slot_free;
  end

  `VRS_ASSERT_ALWAYS(a_top_in_range, clk_i, !rst_ni || CMP_W'(top_q) <= CMP_STK)
  `VRS_ASSERT(a_top_holds_trailer, clk_i, rst_ni, top_q == '0 || top_q > TOP_LEN)
  `VRS_ASSERT(a_reject_in_record, clk_i, rst_ni, rej_q |-> left_q != '0)
  `VRS_ASSERT(a_walk_bounded, clk_i, rst_ni, cnt_q <= MAX_L)

endmodule
